// ===== rtl/cc20_pkg.sv =====
`default_nettype none
package cc20_pkg;
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_01   = 3'd0,
        REG_KEY_23   = 3'd1,
        REG_KEY_45   = 3'd2,
        REG_KEY_67   = 3'd3,
        REG_NONCE_01 = 3'd4,
        REG_NONCE_2  = 3'd5,
        REG_INIT_CTR = 3'd6
    } t_cfg_idx;

    typedef logic [15:0][31:0] t_matrix;

    // item travelling from the front part to the back part
    typedef struct packed {
        logic        gen;
        logic [3:0]  pos;
        logic [31:0] text;
        logic [31:0] ctr;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ROUND = 2'd1,
        ST_ADD   = 2'd2
    } t_gen_state;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        ta = a; tb = b; tc = c; td = d;
        ta = ta + tb; td = rotl(td ^ ta, 16);
        tc = tc + td; tb = rotl(tb ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        quarter = {ta, tb, tc, td};
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] v);
        bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction
endpackage
`default_nettype wire

// ===== rtl/cc20_front.sv =====
`default_nettype none
module cc20_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic             i_start_message,
    input  wire logic [31:0]      i_text_word,
    input  wire logic [31:0]      i_init_ctr,
    output cc20_pkg::t_job        o_job
);
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_ctr, n_ctr;
    logic [3:0]  w_pos;
    logic [31:0] w_ctr;

    always_comb begin
        w_pos = i_start_message ? 4'd0 : r_pos;
        w_ctr = i_start_message ? i_init_ctr : r_ctr;
        o_job.gen  = (w_pos == 4'd0);
        o_job.pos  = w_pos;
        o_job.text = i_text_word;
        o_job.ctr  = w_ctr;
        n_pos = w_pos + 4'd1;
        n_ctr = (w_pos == 4'd15) ? w_ctr + 32'd1 : w_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ctr <= '0;
        end else if (i_take) begin
            r_pos <= n_pos;
            r_ctr <= n_ctr;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cc20_queue.sv =====
`default_nettype none
module cc20_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cc20_pkg::t_job  i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output cc20_pkg::t_job       o_data,
    output logic                 o_empty
);
    localparam int AW = $clog2(DEPTH);
    cc20_pkg::t_job r_mem [DEPTH];
    logic [AW:0] r_wr, r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wr[AW-1:0]] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cc20_back.sv =====
`default_nettype none
module cc20_back #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cc20_pkg::t_job  i_job,
    input  wire logic            i_job_valid,
    output logic                 o_job_take,
    input  wire logic [63:0]     i_key_01,
    input  wire logic [63:0]     i_key_23,
    input  wire logic [63:0]     i_key_45,
    input  wire logic [63:0]     i_key_67,
    input  wire logic [63:0]     i_nonce_01,
    input  wire logic [31:0]     i_nonce_2,
    output logic [31:0]          o_cipher_word,
    output logic                 o_block_end,
    output logic                 o_empty,
    input  wire logic            i_pop
);
    // one half round (column or diagonal) per cycle
    localparam int HALF = 2 * DOUBLE_ROUNDS;
    localparam int CW   = $clog2(HALF);

    cc20_pkg::t_gen_state r_st, n_st;
    cc20_pkg::t_matrix r_init, r_work, r_ks, w_half, w_init;
    logic [CW-1:0] r_cnt;
    logic          r_ks_ok;
    logic          r_out_v;
    logic          w_emit, w_start, w_out_free;

    always_comb begin
        w_init[0]  = cc20_pkg::SIGMA_0;
        w_init[1]  = cc20_pkg::SIGMA_1;
        w_init[2]  = cc20_pkg::SIGMA_2;
        w_init[3]  = cc20_pkg::SIGMA_3;
        w_init[4]  = i_key_01[31:0];
        w_init[5]  = i_key_01[63:32];
        w_init[6]  = i_key_23[31:0];
        w_init[7]  = i_key_23[63:32];
        w_init[8]  = i_key_45[31:0];
        w_init[9]  = i_key_45[63:32];
        w_init[10] = i_key_67[31:0];
        w_init[11] = i_key_67[63:32];
        w_init[12] = i_job.ctr;
        w_init[13] = i_nonce_01[31:0];
        w_init[14] = i_nonce_01[63:32];
        w_init[15] = i_nonce_2;
    end

    always_comb begin
        w_half = r_work;
        if (!r_cnt[0]) begin
            for (int c = 0; c < 4; c++)
                {w_half[c], w_half[c+4], w_half[c+8], w_half[c+12]} =
                    cc20_pkg::quarter(r_work[c], r_work[c+4], r_work[c+8], r_work[c+12]);
        end else begin
            for (int c = 0; c < 4; c++)
                {w_half[c], w_half[4+((c+1)%4)], w_half[8+((c+2)%4)],
                 w_half[12+((c+3)%4)]} =
                    cc20_pkg::quarter(r_work[c], r_work[4+((c+1)%4)],
                                      r_work[8+((c+2)%4)], r_work[12+((c+3)%4)]);
        end
    end

    assign w_out_free = !r_out_v || i_pop;
    assign w_start = (r_st == cc20_pkg::ST_IDLE) && i_job_valid && i_job.gen && !r_ks_ok;
    assign w_emit  = (r_st == cc20_pkg::ST_IDLE) && i_job_valid
                     && (!i_job.gen || r_ks_ok) && w_out_free;
    assign o_job_take = w_emit;
    assign o_empty = !r_out_v;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            cc20_pkg::ST_IDLE:  if (w_start) n_st = cc20_pkg::ST_ROUND;
            cc20_pkg::ST_ROUND: if (r_cnt == CW'(HALF - 1)) n_st = cc20_pkg::ST_ADD;
            cc20_pkg::ST_ADD:   n_st = cc20_pkg::ST_IDLE;
            default:            n_st = cc20_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= cc20_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_ks_ok <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == cc20_pkg::ST_ROUND) r_cnt <= r_cnt + 1'b1;
            else r_cnt <= '0;
            // a generate job stays at the head; once the block is ready it emits
            if (r_st == cc20_pkg::ST_ADD) r_ks_ok <= 1'b1;
            else if (w_emit && i_job.gen) r_ks_ok <= 1'b0;
            if (w_emit) r_out_v <= 1'b1;
            else if (i_pop) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_init <= w_init;
            r_work <= w_init;
        end else if (r_st == cc20_pkg::ST_ROUND) begin
            r_work <= w_half;
        end
        if (r_st == cc20_pkg::ST_ADD) begin
            for (int i = 0; i < 16; i++) r_ks[i] <= r_work[i] + r_init[i];
        end
        if (w_emit) begin
            o_cipher_word <= i_job.text ^ cc20_pkg::bswap(r_ks[i_job.pos]);
            o_block_end   <= (i_job.pos == 4'd15);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/chacha20_stream_cipher.sv =====
// ChaCha20 stream cipher, one 32-bit text word per transfer.
// Input queue side: push / full carry i_start_message and i_text_word.
// Result queue side: empty / pop carry o_cipher_word and o_block_end.
// Config: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index selects the
// register (key pairs 0..3, nonce pair 4, nonce word 2 at 5, counter 6);
// write only while the block is idle.
// The front tracks word position and block counter and tags each word; a
// 4-entry queue feeds the back, which owns the block function.
// Word 0 of each block waits at the head of the queue for the keystream
// (one half round per cycle); the other 15 words go one per cycle while
// the receiver keeps popping. Each result is registered as its word leaves
// the head of the queue.
// Reset clears position, counter, queue and configuration registers. When the receiver
// stalls the result register holds, the queue fills and full rises.
`default_nettype none
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_start_message,
    input  wire logic [31:0] i_text_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_cipher_word,
    output logic             o_block_end,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [63:0] r_key_01, r_key_23, r_key_45, r_key_67, r_nonce_01;
    logic [31:0] r_nonce_2, r_init_ctr;
    cc20_pkg::t_job w_job_in, w_job_q;
    logic w_take, w_q_empty, w_q_full;
    logic w_job_take;

    assign o_cfg_ready = 1'b1;
    assign full = w_q_full;
    assign w_take = push && !w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_01 <= '0; r_key_23 <= '0; r_key_45 <= '0; r_key_67 <= '0;
            r_nonce_01 <= '0; r_nonce_2 <= '0; r_init_ctr <= '0;
        end else if (i_cfg_valid) begin
            case (cc20_pkg::t_cfg_idx'(i_cfg_index))
                cc20_pkg::REG_KEY_01:   r_key_01   <= i_cfg_data;
                cc20_pkg::REG_KEY_23:   r_key_23   <= i_cfg_data;
                cc20_pkg::REG_KEY_45:   r_key_45   <= i_cfg_data;
                cc20_pkg::REG_KEY_67:   r_key_67   <= i_cfg_data;
                cc20_pkg::REG_NONCE_01: r_nonce_01 <= i_cfg_data;
                cc20_pkg::REG_NONCE_2:  r_nonce_2  <= i_cfg_data[31:0];
                cc20_pkg::REG_INIT_CTR: r_init_ctr <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    cc20_front u_front (
        .i_clk, .i_rst_n, .i_take(w_take), .i_start_message, .i_text_word,
        .i_init_ctr(r_init_ctr), .o_job(w_job_in)
    );

    cc20_queue #(.DEPTH(4)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data(w_job_in), .o_full(w_q_full),
        .i_pop(w_job_take), .o_data(w_job_q), .o_empty(w_q_empty)
    );

    cc20_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
        .i_clk, .i_rst_n, .i_job(w_job_q), .i_job_valid(!w_q_empty),
        .o_job_take(w_job_take),
        .i_key_01(r_key_01), .i_key_23(r_key_23), .i_key_45(r_key_45),
        .i_key_67(r_key_67), .i_nonce_01(r_nonce_01), .i_nonce_2(r_nonce_2),
        .o_cipher_word, .o_block_end, .o_empty(empty), .i_pop(pop)
    );

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !w_take) else $error("transfer into a full queue");
    a_emit_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_take |=> !empty) else $error("result lost");
    a_gen_not_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_job_take && w_job_q.gen) |-> $past(u_back.r_st) == cc20_pkg::ST_ADD ||
        $past(u_back.r_st) == cc20_pkg::ST_IDLE) else $error("word 0 before keystream");
endmodule
`default_nettype wire
